// ===== design/blur_upscale_1to3_line_defines.svh =====
// assertion macros for the horizontal 3x line upscaler
// used by the top level, expects signals clk and rst in scope
`ifndef BLUR_UPSCALE_1TO3_LINE_DEFINES_SVH
`define BLUR_UPSCALE_1TO3_LINE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BU3_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upscaler check failed");

// next-cycle implication, disabled while in reset
`define BU3_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upscaler check failed");

`endif

// ===== design/bu3_pkg.sv =====
// shared types, constants and weight helper for the 3x line upscaler
// no dependencies
`default_nettype none

package bu3_pkg;

  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = PIX_W / CH_W;
  localparam int BLUR_W     = 7;
  localparam int WGT_W      = 9;
  localparam int WEIGHT_ONE = 256;
  localparam int SUM_W      = WGT_W + CH_W + 1;

  // blend weights derived from the blur setting
  typedef struct packed {
    logic [WGT_W-1:0] w0;
    logic [WGT_W-1:0] w1;
    logic [WGT_W-1:0] w2;
    logic [WGT_W-1:0] w3;
  } weights_t;

  // weights applied to left, center and right neighbor
  typedef struct packed {
    logic [WGT_W-1:0] wp;
    logic [WGT_W-1:0] wc;
    logic [WGT_W-1:0] wn;
  } tap_wgt_t;

  // which of the three output pixels of a source pixel is being produced
  typedef enum logic [1:0] {
    PH_LEFT,
    PH_MID,
    PH_RIGHT
  } phase_t;

  function automatic weights_t calc_weights(input logic [BLUR_W-1:0] blur);
    weights_t         w;
    logic [WGT_W-1:0] half;
    half = WGT_W'(blur >> 1);
    w.w0 = half;
    w.w1 = WGT_W'(blur) + half;
    w.w2 = WGT_W'(WEIGHT_ONE) - w.w1;
    w.w3 = WGT_W'(WEIGHT_ONE) - (half << 1);
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/blur_upscale_1to3_line.sv =====
// top level of the horizontal 3x line upscaler with linear blur
// depends on bu3_pkg, bu3_weights, bu3_mix and the assertion macro header
`default_nettype none
`include "blur_upscale_1to3_line_defines.svh"

// Each source pixel of a scan line yields three output pixels, blended with
// its left and right neighbors by weights set from blur_strength (cfg_data);
// border pixels repeat themselves. The outputs of a pixel come out when its
// right neighbor arrives, or at once when s_axis_tlast marks it as the line's
// last pixel, in which case the last pixel's three outputs follow (six in
// all); m_axis_tlast marks the final output caused by each input item. The
// first pixel of a line is absorbed with no output. One output pixel leaves
// per cycle through the output register while m_axis_tready does not stall
// it. A new item is accepted in the same cycle the held item issues its
// final output.
module blur_upscale_1to3_line (
  input  wire logic        clk,
  input  wire logic        rst,
  // input pixels
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] in_pixel
  input  wire logic        s_axis_tlast,   // line_end
  // output pixels
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] out_pixel
  output logic             m_axis_tlast,   // last_of_run
  // blur setting
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data        // [6:0] blur_strength
);
  import bu3_pkg::*;

  weights_t           weights;
  tap_wgt_t           taps;
  logic               hold_valid;
  logic [PIX_W-1:0]   hold_pixel;
  logic               hold_last;
  logic               started;
  logic [PIX_W-1:0]   prev_pixel;
  logic [PIX_W-1:0]   curr_pixel;
  logic               grp;
  phase_t             phase;
  logic [PIX_W-1:0]   tap_p;
  logic [PIX_W-1:0]   tap_c;
  logic [PIX_W-1:0]   tap_n;
  logic [PIX_W-1:0]   mixed;
  logic               out_free;
  logic               empty_item;
  logic               two_groups;
  logic               emit;
  logic               final_emit;
  logic               done;

  bu3_weights u_weights (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .weights   (weights)
  );

  // issue control for the held item
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign empty_item    = hold_valid && !started && !hold_last;
  assign two_groups    = started && hold_last;
  assign emit          = hold_valid && !empty_item && out_free;
  assign final_emit    = emit && (phase == PH_RIGHT) && (grp || !two_groups);
  assign done          = empty_item || final_emit;
  assign s_axis_tready = !hold_valid || done;

  // neighbor selection: first group uses held pixels, second the last pixel
  always_comb begin
    if (!grp && started) begin
      tap_p = prev_pixel;
      tap_c = curr_pixel;
      tap_n = hold_pixel;
    end else begin
      tap_p = started ? curr_pixel : hold_pixel;
      tap_c = hold_pixel;
      tap_n = hold_pixel;
    end
  end

  // weights for the output being produced
  always_comb begin
    case (phase)
      PH_LEFT:  taps = '{wp: weights.w1, wc: weights.w2, wn: '0};
      PH_MID:   taps = '{wp: weights.w0, wc: weights.w3, wn: weights.w0};
      PH_RIGHT: taps = '{wp: '0, wc: weights.w2, wn: weights.w1};
      default:  taps = '{wp: '0, wc: '0, wn: '0};
    endcase
  end

  bu3_mix u_mix (
    .prev_px (tap_p),
    .cur_px  (tap_c),
    .next_px (tap_n),
    .taps    (taps),
    .mixed   (mixed)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_axis_tready) begin
      hold_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold_pixel <= s_axis_tdata;
      hold_last  <= s_axis_tlast;
    end
  end

  // output counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEFT;
      grp   <= 1'b0;
    end else if (emit) begin
      case (phase)
        PH_LEFT:  phase <= PH_MID;
        PH_MID:   phase <= PH_RIGHT;
        default: begin
          phase <= PH_LEFT;
          grp   <= !final_emit;
        end
      endcase
    end
  end

  // line state, updated when the held item is finished
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (done) begin
      started <= !hold_last;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      prev_pixel <= started ? curr_pixel : hold_pixel;
      curr_pixel <= hold_pixel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= mixed;
      m_axis_tlast <= final_emit;
    end
  end

  // checks
  `BU3_ASSERT_IMP(a_grp_only_on_line_end, grp, hold_valid && started && hold_last)
  `BU3_ASSERT_IMP(a_no_take_mid_item, emit && !final_emit, !s_axis_tready)
  `BU3_ASSERT_NEXT(a_line_end_clears, done && hold_last, !started && !grp)

endmodule

`default_nettype wire

// ===== design/bu3_weights.sv =====
// blur setting register, holds the precomputed blend weights
// depends on bu3_pkg
`default_nettype none

module bu3_weights (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [bu3_pkg::BLUR_W-1:0] cfg_data,
  output bu3_pkg::weights_t              weights
);
  import bu3_pkg::*;

  // always able to take a write
  assign cfg_ready = 1'b1;

  // weights updated on each write, plain tripling after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      weights <= calc_weights(BLUR_W'(0));
    end else if (cfg_valid) begin
      weights <= calc_weights(cfg_data);
    end
  end

endmodule

`default_nettype wire

// ===== design/bu3_mix.sv =====
// per-channel weighted blend of three neighboring pixels
// depends on bu3_pkg
`default_nettype none

module bu3_mix (
  input  wire logic [bu3_pkg::PIX_W-1:0] prev_px,
  input  wire logic [bu3_pkg::PIX_W-1:0] cur_px,
  input  wire logic [bu3_pkg::PIX_W-1:0] next_px,
  input  wire bu3_pkg::tap_wgt_t          taps,
  output logic [bu3_pkg::PIX_W-1:0]      mixed
);
  import bu3_pkg::*;

  logic [SUM_W-1:0] sum [NUM_CH];

  // weights sum to one, so bits above the shifted byte stay zero
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum[ch] = SUM_W'(taps.wp) * SUM_W'(prev_px[ch*CH_W +: CH_W])
              + SUM_W'(taps.wc) * SUM_W'(cur_px[ch*CH_W +: CH_W])
              + SUM_W'(taps.wn) * SUM_W'(next_px[ch*CH_W +: CH_W]);
      mixed[ch*CH_W +: CH_W] = sum[ch][CH_W +: CH_W];
    end
  end

endmodule

`default_nettype wire
